@@ hw/rtl/efa_pkg.sv @@
// ----------------------------------------------------------------------------
// efa_pkg
// Shared widths, fixed-point constants and latencies of the erf datapath.
// ----------------------------------------------------------------------------
package efa_pkg;

    // port payload widths
    localparam int ARG_W             = 16;
    localparam int ERF_W             = 16;
    localparam int ARG_FRAC_BITS_DEF = 12;

    // internal fixed-point formats
    localparam int QF      = 30;   // Q30 working fraction
    localparam int XF      = 24;   // magnitude held in Q24
    localparam int XA_W    = 28;   // clamped magnitude, up to 8.0 in Q24
    localparam int P_W     = 29;
    localparam int DENOM_W = 32;
    localparam int T_W     = 31;   // t in (0, 1.0] Q30
    localparam int S_W     = 37;   // a*a in Q30, up to 64.0
    localparam int ACC_W   = 32;   // signed Horner accumulator
    localparam int POLY_W  = 31;
    localparam int E_W     = 31;
    localparam int K_W     = 7;    // exponent of two, below 128
    localparam int R_W     = 30;   // reduced argument, below ln2

    localparam logic [XA_W-1:0] X_CLAMP = XA_W'(134217728);   // 8.0
    localparam logic [P_W-1:0]  P_Q30   = P_W'(351748265);
    localparam logic [R_W-1:0]  LN2_Q30 = R_W'(744261118);

    // Horner coefficients a1..a5 in Q30
    localparam int POLY_TERMS = 5;
    localparam logic signed [ACC_W-1:0] POLY_COEF [POLY_TERMS] = '{
        32'sd273621191, -32'sd305476044, 32'sd1526231383,
        -32'sd1560310108, 32'sd1139675401
    };

    // Taylor terms of exp(-r), step i divides by n = TAYLOR_TERMS - i.
    // floor(q / n) = (q * MUL) >> SHIFT for q below 2^31.
    localparam int TAYLOR_TERMS = 10;
    localparam int TAYLOR_SHIFT [TAYLOR_TERMS] = '{35, 35, 34, 34, 34, 34, 33, 33, 32, 31};
    localparam logic [63:0] TAYLOR_MUL [TAYLOR_TERMS] = '{
        ((64'd1 << 35) + 64'd9) / 64'd10,
        ((64'd1 << 35) + 64'd8) / 64'd9,
        (64'd1 << 34) / 64'd8,
        ((64'd1 << 34) + 64'd6) / 64'd7,
        ((64'd1 << 34) + 64'd5) / 64'd6,
        ((64'd1 << 34) + 64'd4) / 64'd5,
        (64'd1 << 33) / 64'd4,
        ((64'd1 << 33) + 64'd2) / 64'd3,
        (64'd1 << 32) / 64'd2,
        (64'd1 << 31) / 64'd1
    };

    localparam int EXP_K_LIMIT = 40;
    localparam int OUT_MAX     = 32767;

    // unit latencies in cycles
    localparam int RECIP_LAT = T_W;
    localparam int POLY_LAT  = 2 * POLY_TERMS;
    localparam int EXP_LAT   = K_W + 2 * TAYLOR_TERMS + 1;
    localparam int E_DLY     = RECIP_LAT + POLY_LAT - EXP_LAT;

endpackage

@@ hw/rtl/efa_arg_if.sv @@
// ----------------------------------------------------------------------------
// efa_arg_if
// Argument channel: valid/ready handshake with one Q3.12 argument.
// ----------------------------------------------------------------------------
interface efa_arg_if
    import efa_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [ARG_W-1:0] arg_value;

    modport source (output valid, output arg_value, input ready);
    modport sink   (input valid, input arg_value, output ready);
endinterface

@@ hw/rtl/efa_erf_if.sv @@
// ----------------------------------------------------------------------------
// efa_erf_if
// Result channel: valid/ready handshake with one Q0.15 erf value.
// ----------------------------------------------------------------------------
interface efa_erf_if
    import efa_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [ERF_W-1:0] erf_value;

    modport source (output valid, output erf_value, input ready);
    modport sink   (input valid, input erf_value, output ready);
endinterface

@@ hw/rtl/efa_recip.sv @@
// ----------------------------------------------------------------------------
// efa_recip
// Pipelined restoring divider: t = round(2^60 / denom), one bit per stage.
// ----------------------------------------------------------------------------
module efa_recip
    import efa_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [DENOM_W-1:0] denom,
    output logic [T_W-1:0]     t
);

    logic [DENOM_W-1:0] rem_reg [T_W];
    logic [DENOM_W-1:0] div_reg [T_W];
    logic [T_W-1:0]     quo_reg [T_W];

    // Dividend is 2^60 + denom/2; its top bits give a partial remainder
    // of 2^29 and its low bits are denom[31:1], taken from the divisor.
    for (genvar i = 0; i < T_W; i++)
    begin : g_step
        logic [DENOM_W-1:0] rem_in;
        logic [DENOM_W-1:0] div_in;
        logic [T_W-1:0]     quo_in;
        logic [DENOM_W:0]   trial;
        logic [DENOM_W:0]   diff;
        logic               take;
        logic [DENOM_W-1:0] rem_next;
        logic [T_W-1:0]     quo_next;

        if (i == 0)
        begin : g_first
            assign rem_in = DENOM_W'(1) << (2 * QF - T_W);
            assign div_in = denom;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign div_in = div_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        // trial subtract
        assign trial    = {rem_in, div_in[DENOM_W-1-i]};
        assign diff     = trial - {1'b0, div_in};
        assign take     = (trial >= {1'b0, div_in});
        assign rem_next = take ? diff[DENOM_W-1:0] : trial[DENOM_W-1:0];
        assign quo_next = {quo_in[T_W-2:0], take};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                div_reg[i] <= div_in;
                quo_reg[i] <= quo_next;
            end
        end
    end

    assign t = quo_reg[T_W-1];

endmodule

@@ hw/rtl/efa_poly.sv @@
// ----------------------------------------------------------------------------
// efa_poly
// Horner evaluation of t*(a1 + t*(a2 + t*(a3 + t*(a4 + t*a5)))), two stages
// per product: multiply, then round, restore sign and add the coefficient.
// ----------------------------------------------------------------------------
module efa_poly
    import efa_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [T_W-1:0]    t,
    output logic [POLY_W-1:0] poly
);

    localparam int PROD_W = ACC_W + T_W;

    logic [PROD_W-1:0]       prod_reg  [POLY_TERMS];
    logic                    neg_reg   [POLY_TERMS];
    logic [T_W-1:0]          t_a_reg   [POLY_TERMS];
    logic signed [ACC_W-1:0] acc_reg   [POLY_TERMS];
    logic [T_W-1:0]          t_b_reg   [POLY_TERMS];

    for (genvar j = 0; j < POLY_TERMS; j++)
    begin : g_term
        logic signed [ACC_W-1:0] acc_in;
        logic [T_W-1:0]          t_in;
        logic [ACC_W-1:0]        mag;
        logic [PROD_W:0]         rnd_sum;
        logic signed [ACC_W+1:0] rnd_val;
        logic signed [ACC_W+1:0] coef;
        logic signed [ACC_W+1:0] acc_next;

        if (j == 0)
        begin : g_first
            assign acc_in = POLY_COEF[POLY_TERMS-1];
            assign t_in   = t;
        end
        else
        begin : g_rest
            assign acc_in = acc_reg[j-1];
            assign t_in   = t_b_reg[j-1];
        end

        if (j < POLY_TERMS - 1)
        begin : g_coef
            assign coef = (ACC_W+2)'(POLY_COEF[POLY_TERMS-2-j]);
        end
        else
        begin : g_last
            assign coef = '0;
        end

        // magnitude product
        assign mag = acc_in[ACC_W-1] ? ACC_W'(-acc_in) : ACC_W'(acc_in);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[j] <= PROD_W'(mag) * PROD_W'(t_in);
                neg_reg[j]  <= acc_in[ACC_W-1];
                t_a_reg[j]  <= t_in;
            end
        end

        // round half away from zero, add next coefficient
        assign rnd_sum  = (PROD_W+1)'(prod_reg[j]) + ((PROD_W+1)'(1) << (QF - 1));
        assign rnd_val  = $signed({1'b0, rnd_sum[QF +: ACC_W+1]});
        assign acc_next = (neg_reg[j] ? -rnd_val : rnd_val) + coef;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[j] <= acc_next[ACC_W-1:0];
                t_b_reg[j] <= t_a_reg[j];
            end
        end
    end

    // a negative polynomial counts as zero
    assign poly = acc_reg[POLY_TERMS-1][ACC_W-1] ? '0 : acc_reg[POLY_TERMS-1][POLY_W-1:0];

endmodule

@@ hw/rtl/efa_exp.sv @@
// ----------------------------------------------------------------------------
// efa_exp
// exp(-s) in Q30: s = k*ln2 + r by a digit-per-stage division, a tenth-order
// Taylor series of exp(-r) in Horner form, then a rounding shift by k.
// ----------------------------------------------------------------------------
module efa_exp
    import efa_pkg::*;
(
    input  logic           clk,
    input  logic           en,
    input  logic [S_W-1:0] s,
    output logic [E_W-1:0] e
);

    localparam int TP_W = R_W + E_W;
    localparam int Q_W  = 31;
    localparam int QM_W = Q_W + 32;

    // ---------------- range reduction ----------------
    logic [S_W-1:0] red_rem_reg [K_W];
    logic [K_W-1:0] red_k_reg   [K_W];

    for (genvar j = 0; j < K_W; j++)
    begin : g_red
        localparam logic [S_W-1:0] STEP = S_W'(LN2_Q30) << (K_W - 1 - j);
        logic [S_W-1:0] rem_in;
        logic [K_W-1:0] k_in;
        logic           take;

        if (j == 0)
        begin : g_first
            assign rem_in = s;
            assign k_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = red_rem_reg[j-1];
            assign k_in   = red_k_reg[j-1];
        end

        assign take = (rem_in >= STEP);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                red_rem_reg[j] <= take ? (rem_in - STEP) : rem_in;
                red_k_reg[j]   <= {k_in[K_W-2:0], take};
            end
        end
    end

    // ---------------- Taylor series ----------------
    logic [TP_W-1:0] tp_prod_reg [TAYLOR_TERMS];
    logic [R_W-1:0]  tp_r_a_reg  [TAYLOR_TERMS];
    logic [K_W-1:0]  tp_k_a_reg  [TAYLOR_TERMS];
    logic [QM_W-1:0] tp_quo_reg  [TAYLOR_TERMS];
    logic [R_W-1:0]  tp_r_b_reg  [TAYLOR_TERMS];
    logic [K_W-1:0]  tp_k_b_reg  [TAYLOR_TERMS];
    logic [E_W-1:0]  tp_acc      [TAYLOR_TERMS];

    for (genvar i = 0; i < TAYLOR_TERMS; i++)
    begin : g_tay
        localparam logic [TP_W:0] HALF_DIV = (TP_W+1)'(TAYLOR_TERMS - i) << (QF - 1);
        localparam logic [31:0]   MUL      = TAYLOR_MUL[i][31:0];
        localparam int            SHIFT    = TAYLOR_SHIFT[i];
        logic [E_W-1:0]  acc_in;
        logic [R_W-1:0]  r_in;
        logic [K_W-1:0]  k_in;
        logic [TP_W:0]   sum;
        logic [Q_W-1:0]  q;

        if (i == 0)
        begin : g_first
            assign acc_in = E_W'(1) << QF;
            assign r_in   = red_rem_reg[K_W-1][R_W-1:0];
            assign k_in   = red_k_reg[K_W-1];
        end
        else
        begin : g_rest
            assign acc_in = tp_acc[i-1];
            assign r_in   = tp_r_b_reg[i-1];
            assign k_in   = tp_k_b_reg[i-1];
        end

        // r * acc
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tp_prod_reg[i] <= TP_W'(r_in) * TP_W'(acc_in);
                tp_r_a_reg[i]  <= r_in;
                tp_k_a_reg[i]  <= k_in;
            end
        end

        // rounded divide by n*2^30: shift, then reciprocal multiply
        assign sum = (TP_W+1)'(tp_prod_reg[i]) + HALF_DIV;
        assign q   = sum[QF +: Q_W];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tp_quo_reg[i] <= QM_W'(q) * QM_W'(MUL);
                tp_r_b_reg[i] <= tp_r_a_reg[i];
                tp_k_b_reg[i] <= tp_k_a_reg[i];
            end
        end

        assign tp_acc[i] = (E_W'(1) << QF) - E_W'(tp_quo_reg[i] >> SHIFT);
    end

    // ---------------- scale by 2^-k ----------------
    logic [E_W-1:0] acc_f;
    logic [K_W-1:0] k_f;
    logic [63:0]    scale_sum;
    logic [E_W-1:0] e_next;
    logic [E_W-1:0] e_reg;

    assign acc_f = tp_acc[TAYLOR_TERMS-1];
    assign k_f   = tp_k_b_reg[TAYLOR_TERMS-1];

    always_comb
    begin
        scale_sum = 64'(acc_f);
        e_next    = acc_f;
        if (k_f >= K_W'(EXP_K_LIMIT))
        begin
            e_next = '0;
        end
        else if (k_f != '0)
        begin
            scale_sum = 64'(acc_f) + (64'd1 << (k_f - K_W'(1)));
            e_next    = E_W'(scale_sum >> k_f);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg <= e_next;
        end
    end

    assign e = e_reg;

endmodule

@@ hw/rtl/error_function_approx_core.sv @@
// ----------------------------------------------------------------------------
// error_function_approx_core
// erf(x) by a fifth-degree rational-exponential approximation, Q3.12 in,
// Q0.15 out.
// ----------------------------------------------------------------------------
//  channel  | dir | payload              | format
//  ---------+-----+----------------------+-----------------------------
//  arg      | in  | arg_value [15:0]     | signed, ARG_FRAC_BITS fraction
//  result   | out | erf_value [15:0]     | signed Q0.15, +/-32767
//
//  One argument per cycle while no result is held; 46 register stages run
//  from the magnitude register to the result register. Most of the depth
//  is the 31-stage reciprocal divider plus 10 Horner stages.
//  The whole pipeline advances together; a held result freezes it and
//  arg.ready drops, so nothing is lost or repeated.
//  Reset clears the valid bits only; no state survives between items.
// ----------------------------------------------------------------------------
module error_function_approx_core
    import efa_pkg::*;
#(
    parameter int ARG_FRAC_BITS = ARG_FRAC_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    efa_arg_if.sink  arg,
    efa_erf_if.source result
);

    localparam int XA_SHIFT    = XF - ARG_FRAC_BITS;
    localparam int WIDE_W      = 40;
    localparam int PX_W        = XA_W + P_W;
    localparam int SQ_W        = 2 * XA_W;
    localparam int PE_W        = POLY_W + E_W;
    localparam int PIPE_STAGES = 3 + RECIP_LAT + POLY_LAT + 2;

    logic                   en;
    logic [PIPE_STAGES-1:0] valid_pipe_reg;
    logic [PIPE_STAGES-1:0] valid_pipe_next;
    logic [PIPE_STAGES-2:0] sign_pipe_reg;

    // global advance: move unless the output holds an untaken result
    assign en        = ~valid_pipe_reg[PIPE_STAGES-1] | result.ready;
    assign arg.ready = en;

    assign valid_pipe_next = {valid_pipe_reg[PIPE_STAGES-2:0], arg.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_pipe_reg <= '0;
        end
        else if (en)
        begin
            valid_pipe_reg <= valid_pipe_next;
        end
    end

    // sign travels alongside the datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign_pipe_reg <= {sign_pipe_reg[PIPE_STAGES-3:0], arg.arg_value[ARG_W-1]};
        end
    end

    // stage 1: magnitude to Q24, clamped at 8.0
    logic [ARG_W-1:0]  mag;
    logic [WIDE_W-1:0] xa_wide;
    logic [XA_W-1:0]   xa_next;
    logic [XA_W-1:0]   xa_reg;

    assign mag     = arg.arg_value[ARG_W-1] ? ARG_W'(-arg.arg_value) : ARG_W'(arg.arg_value);
    assign xa_wide = WIDE_W'(mag) << XA_SHIFT;
    assign xa_next = (xa_wide > WIDE_W'(X_CLAMP)) ? X_CLAMP : xa_wide[XA_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg <= xa_next;
        end
    end

    // stage 2: p*a and a*a
    logic [PX_W-1:0] px_prod_reg;
    logic [SQ_W-1:0] sq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_prod_reg <= PX_W'(P_Q30) * PX_W'(xa_reg);
            sq_reg      <= SQ_W'(xa_reg) * SQ_W'(xa_reg);
        end
    end

    // stage 3: round to Q30, form denominator and s
    logic [PX_W:0]        px_sum;
    logic [SQ_W:0]        sq_sum;
    logic [DENOM_W-1:0]   denom_next;
    logic [DENOM_W-1:0]   denom_reg;
    logic [S_W-1:0]       s_reg;

    assign px_sum     = (PX_W+1)'(px_prod_reg) + ((PX_W+1)'(1) << (XF - 1));
    assign sq_sum     = (SQ_W+1)'(sq_reg) + ((SQ_W+1)'(1) << (2 * XF - QF - 1));
    assign denom_next = (DENOM_W'(1) << QF) + px_sum[XF +: DENOM_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            denom_reg <= denom_next;
            s_reg     <= sq_sum[(2 * XF - QF) +: S_W];
        end
    end

    // reciprocal, then polynomial
    logic [T_W-1:0]    t;
    logic [POLY_W-1:0] poly;

    efa_recip u_recip (
        .clk   (clk),
        .en    (en),
        .denom (denom_reg),
        .t     (t)
    );

    efa_poly u_poly (
        .clk  (clk),
        .en   (en),
        .t    (t),
        .poly (poly)
    );

    // exponential, delayed to line up with the polynomial
    logic [E_W-1:0] e;
    logic [E_W-1:0] e_dly_reg [E_DLY];

    efa_exp u_exp (
        .clk (clk),
        .en  (en),
        .s   (s_reg),
        .e   (e)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_dly_reg[0] <= e;
            for (int i = 1; i < E_DLY; i++)
            begin
                e_dly_reg[i] <= e_dly_reg[i-1];
            end
        end
    end

    // poly * exp(-a*a)
    logic [PE_W-1:0] pe_prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pe_prod_reg <= PE_W'(poly) * PE_W'(e_dly_reg[E_DLY-1]);
        end
    end

    // final: 1 - pe, round to Q0.15, saturate, restore sign
    logic [PE_W:0]           pe_sum;
    logic [PE_W-QF:0]        pe;
    logic [QF:0]             y;
    logic [QF:0]             y_sum;
    logic [ERF_W-1:0]        r15;
    logic [ERF_W-1:0]        out_mag;
    logic signed [ERF_W-1:0] erf_next;
    logic signed [ERF_W-1:0] erf_reg;

    assign pe_sum   = (PE_W+1)'(pe_prod_reg) + ((PE_W+1)'(1) << (QF - 1));
    assign pe       = pe_sum[PE_W:QF];
    assign y        = (pe >= ((PE_W-QF+1)'(1) << QF)) ? '0
                      : ((QF+1)'(1) << QF) - (QF+1)'(pe);
    assign y_sum    = y + ((QF+1)'(1) << 14);
    assign r15      = y_sum[15 +: ERF_W];
    assign out_mag  = (r15 > ERF_W'(OUT_MAX)) ? ERF_W'(OUT_MAX) : r15;
    assign erf_next = sign_pipe_reg[PIPE_STAGES-2] ? $signed(-out_mag) : $signed(out_mag);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            erf_reg <= erf_next;
        end
    end

    assign result.valid     = valid_pipe_reg[PIPE_STAGES-1];
    assign result.erf_value = erf_reg;

endmodule
